FILE: hw/rtl/arctu_pkg.sv
// Shared types, codes and constants of the affine rotation transform unit.
package arctu_pkg;

  // Default parameter values
  localparam int FRACTION_BITS_DEF      = 16;
  localparam int QUARTER_SINE_DEPTH_DEF = 1024;

  // Field and datapath widths
  localparam int OPCODE_W = 4;
  localparam int ANGLE_W  = 16;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 4;
  localparam int TRIG_W   = 17;  // signed Q1.15 sine/cosine, +-32768
  localparam int COEF_W   = 18;  // signed Q15 rotation coefficient
  localparam int PROD_W   = 50;
  localparam int ACC_W    = 56;
  localparam int ELEM_CNT = 12;
  localparam int COEF_STEPS = 15;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_IDENTITY     = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_SCALE        = 4'd1;
  localparam logic [OPCODE_W-1:0] OP_TRANSLATE    = 4'd2;
  localparam logic [OPCODE_W-1:0] OP_ROTX         = 4'd3;
  localparam logic [OPCODE_W-1:0] OP_ROTY         = 4'd4;
  localparam logic [OPCODE_W-1:0] OP_ROTZ         = 4'd5;
  localparam logic [OPCODE_W-1:0] OP_EULER_ROT    = 4'd6;
  localparam logic [OPCODE_W-1:0] OP_SET_EULER    = 4'd7;
  localparam logic [OPCODE_W-1:0] OP_RESET_ORIENT = 4'd8;

  // Sine/cosine slots
  localparam logic [2:0] TRIG_SX = 3'd0;
  localparam logic [2:0] TRIG_CX = 3'd1;
  localparam logic [2:0] TRIG_SY = 3'd2;
  localparam logic [2:0] TRIG_CY = 3'd3;
  localparam logic [2:0] TRIG_SZ = 3'd4;
  localparam logic [2:0] TRIG_CZ = 3'd5;

  // Pair product slots
  localparam logic [2:0] PAIR_XY  = 3'd0;  // sX * sY
  localparam logic [2:0] PAIR_XCY = 3'd1;  // sX * cY

  // Result destinations
  localparam logic [1:0] DST_PAIR = 2'd0;
  localparam logic [1:0] DST_COEF = 2'd1;
  localparam logic [1:0] DST_MAT  = 2'd2;

  // Operand selects
  localparam logic ASEL_TRIG = 1'b0;
  localparam logic ASEL_PAIR = 1'b1;
  localparam logic BSEL_TRIG = 1'b0;
  localparam logic BSEL_ONE  = 1'b1;

  // Control carried along the MAC pipeline
  typedef struct packed {
    logic       fin;   // last term: round and write result
    logic       clr;   // first term: start a new sum
    logic       neg;   // subtract this term
    logic       sh;    // term carries an extra factor of 2^15
    logic [1:0] dsel;
    logic [3:0] didx;
  } mac_ctl_t;

  // One step of the coefficient program
  typedef struct packed {
    logic     asel;
    logic [2:0] aidx;
    logic     bsel;
    logic [2:0] bidx;
    mac_ctl_t ctl;
  } coef_uop_t;

  function automatic coef_uop_t mk_uop(input logic asel, input logic [2:0] aidx,
                                       input logic bsel, input logic [2:0] bidx,
                                       input logic fin, input logic clr,
                                       input logic neg, input logic sh,
                                       input logic [1:0] dsel, input logic [3:0] didx);
    coef_uop_t u;
    u.asel     = asel;
    u.aidx     = aidx;
    u.bsel     = bsel;
    u.bidx     = bidx;
    u.ctl.fin  = fin;
    u.ctl.clr  = clr;
    u.ctl.neg  = neg;
    u.ctl.sh   = sh;
    u.ctl.dsel = dsel;
    u.ctl.didx = didx;
    return u;
  endfunction

  // Euler coefficient program; coefficient index is row*3+col
  function automatic coef_uop_t coef_uop(input logic [3:0] step);
    coef_uop_t u;
    unique case (step)
      4'd0:  u = mk_uop(ASEL_TRIG, TRIG_SX, BSEL_TRIG, TRIG_SY,
                        1'b1, 1'b1, 1'b0, 1'b0, DST_PAIR, 4'd0);
      4'd1:  u = mk_uop(ASEL_TRIG, TRIG_SX, BSEL_TRIG, TRIG_CY,
                        1'b1, 1'b1, 1'b0, 1'b0, DST_PAIR, 4'd1);
      4'd2:  u = mk_uop(ASEL_TRIG, TRIG_CZ, BSEL_TRIG, TRIG_CY,
                        1'b0, 1'b1, 1'b0, 1'b1, DST_COEF, 4'd0);
      4'd3:  u = mk_uop(ASEL_PAIR, PAIR_XY, BSEL_TRIG, TRIG_SZ,
                        1'b1, 1'b0, 1'b1, 1'b0, DST_COEF, 4'd0);
      4'd4:  u = mk_uop(ASEL_PAIR, PAIR_XY, BSEL_TRIG, TRIG_CZ,
                        1'b0, 1'b1, 1'b0, 1'b0, DST_COEF, 4'd3);
      4'd5:  u = mk_uop(ASEL_TRIG, TRIG_SZ, BSEL_TRIG, TRIG_CY,
                        1'b1, 1'b0, 1'b0, 1'b1, DST_COEF, 4'd3);
      4'd6:  u = mk_uop(ASEL_TRIG, TRIG_CX, BSEL_TRIG, TRIG_SY,
                        1'b1, 1'b1, 1'b1, 1'b1, DST_COEF, 4'd6);
      4'd7:  u = mk_uop(ASEL_TRIG, TRIG_SZ, BSEL_TRIG, TRIG_CX,
                        1'b1, 1'b1, 1'b1, 1'b1, DST_COEF, 4'd1);
      4'd8:  u = mk_uop(ASEL_TRIG, TRIG_CZ, BSEL_TRIG, TRIG_CX,
                        1'b1, 1'b1, 1'b0, 1'b1, DST_COEF, 4'd4);
      4'd9:  u = mk_uop(ASEL_TRIG, TRIG_SX, BSEL_ONE, TRIG_SX,
                        1'b1, 1'b1, 1'b0, 1'b1, DST_COEF, 4'd7);
      4'd10: u = mk_uop(ASEL_PAIR, PAIR_XCY, BSEL_TRIG, TRIG_SZ,
                        1'b0, 1'b1, 1'b0, 1'b0, DST_COEF, 4'd2);
      4'd11: u = mk_uop(ASEL_TRIG, TRIG_CZ, BSEL_TRIG, TRIG_SY,
                        1'b1, 1'b0, 1'b0, 1'b1, DST_COEF, 4'd2);
      4'd12: u = mk_uop(ASEL_TRIG, TRIG_SZ, BSEL_TRIG, TRIG_SY,
                        1'b0, 1'b1, 1'b0, 1'b1, DST_COEF, 4'd5);
      4'd13: u = mk_uop(ASEL_PAIR, PAIR_XCY, BSEL_TRIG, TRIG_CZ,
                        1'b1, 1'b0, 1'b1, 1'b0, DST_COEF, 4'd5);
      default: u = mk_uop(ASEL_TRIG, TRIG_CX, BSEL_TRIG, TRIG_CY,
                          1'b1, 1'b1, 1'b0, 1'b1, DST_COEF, 4'd8);
    endcase
    return u;
  endfunction

endpackage

FILE: hw/rtl/affine_rotation_transform_unit_core.sv
// Top level: sequencer, matrix state and result stream of the transform unit.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+--------------------------------------------
//  in_      | in  | in_tvalid/in_tready | tuser: opcode; tdata: angles xyz, values xyz
//  out_     | out | tvalid/tready/tlast | tuser: element_index; tdata: element_value
//
// One item at a time; in_tready is high only while idle. Set, scale, translate,
// reset-orientation and unknown opcodes go from accept straight to 12 output beats. Axis
// rotations, set Euler and Euler compose first run sine ROM reads, 15 coefficient MAC
// steps (Euler opcodes only), 16 (axis) or 36 (compose) matrix MAC steps on the one
// shared multiplier, pipeline drains and a commit step. Reset loads identity. Output
// stalls hold the block in its output phase.
module affine_rotation_transform_unit_core #(
  parameter int FRACTION_BITS      = arctu_pkg::FRACTION_BITS_DEF,
  parameter int QUARTER_SINE_DEPTH = arctu_pkg::QUARTER_SINE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [3:0]   in_tuser,   // [3:0] opcode
  input  logic [143:0] in_tdata,   // angle_x, angle_y, angle_z, value_x, value_y, value_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [3:0]   out_tuser,  // [3:0] element_index
  output logic [31:0]  out_tdata,  // [31:0] element_value
  output logic         out_tlast
);

  localparam int VW = arctu_pkg::VALUE_W;
  localparam int CW = arctu_pkg::COEF_W;
  localparam int TW = arctu_pkg::TRIG_W;
  localparam int UP_SH = (FRACTION_BITS >= 15) ? FRACTION_BITS - 15 : 0;
  localparam int DN_SH = (FRACTION_BITS < 15) ? 15 - FRACTION_BITS : 1;
  localparam logic signed [VW-1:0] ONE_FIX = 32'sd1 <<< FRACTION_BITS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_TRIG   = 3'd1;
  localparam logic [2:0] ST_COEF   = 3'd2;
  localparam logic [2:0] ST_CDRAIN = 3'd3;
  localparam logic [2:0] ST_APPLY  = 3'd4;
  localparam logic [2:0] ST_ADRAIN = 3'd5;
  localparam logic [2:0] ST_COMMIT = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  logic [2:0]  state_r;
  logic [3:0]  cnt_r;
  logic [3:0]  e_r;
  logic [1:0]  t_r;
  logic [3:0]  oidx_r;
  logic [3:0]  op_r;
  logic [15:0] ang_r [3];
  logic signed [TW-1:0] trig_r [6];
  logic signed [VW-1:0] pair_r [2];
  logic signed [CW-1:0] coef_r [9];
  logic signed [VW-1:0] m_r    [12];
  logic signed [VW-1:0] new_r  [12];

  logic                 accept;
  logic                 issue;
  logic [15:0]          trig_angle;
  logic signed [TW-1:0] sine_value;
  logic signed [VW-1:0] a_op;
  logic signed [CW-1:0] b_op;
  arctu_pkg::mac_ctl_t  ctl;
  arctu_pkg::mac_ctl_t  res_ctl;
  logic signed [VW-1:0] res_value;
  arctu_pkg::coef_uop_t uop;
  logic [3:0]           ri;
  logic [3:0]           rj;
  logic [1:0]           fixk;
  logic [2:0]           sidx;
  logic [2:0]           cidx;
  logic [3:0]           rbase;
  logic [3:0]           cbase;
  logic [1:0]           ck;
  logic [3:0]           kidx;
  logic                 is_compose;

  // Q15 coefficient to the matrix fixed-point format
  function automatic logic signed [VW-1:0] frac_of(input logic signed [CW-1:0] c);
    logic signed [47:0] w;
    if (FRACTION_BITS >= 15) begin
      w = 48'(c) <<< UP_SH;
    end else begin
      w = (48'(c) + (48'sd1 <<< (DN_SH - 1))) >>> DN_SH;
    end
    if (w > 48'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (w < -48'sd2147483648) begin
      return 32'sh80000000;
    end
    return w[31:0];
  endfunction

  // First matrix row of element e's column
  function automatic logic [3:0] col_base(input logic [3:0] e);
    logic [3:0] b;
    unique case (e)
      4'd0, 4'd1, 4'd2:  b = 4'd0;
      4'd3, 4'd4, 4'd5:  b = 4'd3;
      4'd6, 4'd7, 4'd8:  b = 4'd6;
      default:           b = 4'd9;
    endcase
    return b;
  endfunction

  assign accept     = (state_r == ST_IDLE) && in_tvalid;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tuser  = oidx_r;
  assign out_tdata  = m_r[oidx_r];
  assign out_tlast  = (oidx_r == 4'd11);
  assign is_compose = (op_r == arctu_pkg::OP_EULER_ROT);

  // Sine ROM; odd slots are cosines (angle plus a quarter turn)
  assign trig_angle = ang_r[cnt_r[2:1]] + (cnt_r[0] ? 16'd16384 : 16'd0);

  arctu_sine #(.QUARTER_SINE_DEPTH(QUARTER_SINE_DEPTH)) u_sine (
    .clk   (clk),
    .angle (trig_angle),
    .value (sine_value)
  );

  // Axis rotation plane; fixk is the row the rotation leaves alone
  always_comb begin
    unique case (op_r)
      arctu_pkg::OP_ROTX: begin
        ri = 4'd1; rj = 4'd2; fixk = 2'd0;
        sidx = arctu_pkg::TRIG_SX; cidx = arctu_pkg::TRIG_CX;
      end
      arctu_pkg::OP_ROTY: begin
        ri = 4'd2; rj = 4'd0; fixk = 2'd1;
        sidx = arctu_pkg::TRIG_SY; cidx = arctu_pkg::TRIG_CY;
      end
      default: begin
        ri = 4'd0; rj = 4'd1; fixk = 2'd2;
        sidx = arctu_pkg::TRIG_SZ; cidx = arctu_pkg::TRIG_CZ;
      end
    endcase
  end

  assign rbase = {e_r[2:0], 1'b0} + e_r;
  assign cbase = col_base(e_r);
  assign ck    = 2'(e_r - cbase);
  assign kidx  = {1'b0, ck, 1'b0} + {2'b00, ck} + {2'b00, t_r};
  assign uop   = arctu_pkg::coef_uop(cnt_r);
  assign issue = (state_r == ST_COEF) || (state_r == ST_APPLY);

  // Operand selection for the shared MAC
  always_comb begin
    a_op = '0;
    b_op = '0;
    ctl  = '0;
    if (state_r == ST_COEF) begin
      a_op = (uop.asel == arctu_pkg::ASEL_PAIR) ? pair_r[uop.aidx[0]]
                                                : VW'(trig_r[uop.aidx]);
      b_op = (uop.bsel == arctu_pkg::BSEL_ONE) ? 18'sd32768 : CW'(trig_r[uop.bidx]);
      ctl  = uop.ctl;
    end else if (is_compose) begin
      a_op     = m_r[cbase + {2'b00, t_r}];
      b_op     = coef_r[kidx];
      ctl.clr  = (t_r == 2'd0);
      ctl.fin  = (t_r == 2'd2);
      ctl.dsel = arctu_pkg::DST_MAT;
      ctl.didx = e_r;
    end else begin
      ctl.dsel = arctu_pkg::DST_MAT;
      unique case (t_r)
        2'd0: begin
          a_op = m_r[rbase + ri]; b_op = CW'(trig_r[cidx]); ctl.clr = 1'b1;
        end
        2'd1: begin
          a_op = m_r[rbase + rj]; b_op = CW'(trig_r[sidx]);
          ctl.neg = 1'b1; ctl.fin = 1'b1; ctl.didx = rbase + ri;
        end
        2'd2: begin
          a_op = m_r[rbase + rj]; b_op = CW'(trig_r[cidx]); ctl.clr = 1'b1;
        end
        default: begin
          a_op = m_r[rbase + ri]; b_op = CW'(trig_r[sidx]);
          ctl.fin = 1'b1; ctl.didx = rbase + rj;
        end
      endcase
    end
  end

  arctu_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .a         (a_op),
    .b         (b_op),
    .ctl       (ctl),
    .res_ctl   (res_ctl),
    .res_value (res_value)
  );

  // Transaction capture, sine slots and MAC write-back
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_tuser;
      ang_r[0] <= in_tdata[15:0];
      ang_r[1] <= in_tdata[31:16];
      ang_r[2] <= in_tdata[47:32];
    end
    if ((state_r == ST_TRIG) && (cnt_r != 4'd0)) begin
      trig_r[3'(cnt_r - 4'd1)] <= sine_value;
    end
    if (res_ctl.fin) begin
      unique case (res_ctl.dsel)
        arctu_pkg::DST_PAIR: pair_r[res_ctl.didx[0]] <= res_value;
        arctu_pkg::DST_COEF: coef_r[res_ctl.didx]    <= res_value[CW-1:0];
        default:             new_r[res_ctl.didx]     <= res_value;
      endcase
    end
  end

  // Sequencer and matrix state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      e_r     <= '0;
      t_r     <= '0;
      oidx_r  <= '0;
      for (int k = 0; k < 12; k++) begin
        m_r[k] <= ((k == 0) || (k == 4) || (k == 8)) ? ONE_FIX : '0;
      end
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            cnt_r  <= '0;
            oidx_r <= '0;
            state_r <= ST_OUT;
            unique case (in_tuser)
              arctu_pkg::OP_IDENTITY: begin
                for (int k = 0; k < 12; k++) begin
                  m_r[k] <= ((k == 0) || (k == 4) || (k == 8)) ? ONE_FIX : '0;
                end
              end
              arctu_pkg::OP_SCALE: begin
                for (int k = 0; k < 12; k++) begin
                  m_r[k] <= ((k == 0) || (k == 4) || (k == 8)) ?
                            $signed(in_tdata[79:48]) : '0;
                end
              end
              arctu_pkg::OP_TRANSLATE: begin
                for (int k = 0; k < 9; k++) begin
                  m_r[k] <= ((k == 0) || (k == 4) || (k == 8)) ? ONE_FIX : '0;
                end
                m_r[9]  <= $signed(in_tdata[79:48]);
                m_r[10] <= $signed(in_tdata[111:80]);
                m_r[11] <= $signed(in_tdata[143:112]);
              end
              arctu_pkg::OP_RESET_ORIENT: begin
                for (int k = 0; k < 9; k++) begin
                  m_r[k] <= ((k == 0) || (k == 4) || (k == 8)) ? ONE_FIX : '0;
                end
              end
              arctu_pkg::OP_ROTX, arctu_pkg::OP_ROTY, arctu_pkg::OP_ROTZ,
              arctu_pkg::OP_EULER_ROT, arctu_pkg::OP_SET_EULER: begin
                state_r <= ST_TRIG;
              end
              default: ;
            endcase
          end
        end
        ST_TRIG: begin
          if (cnt_r == 4'd6) begin
            cnt_r <= '0;
            e_r   <= '0;
            t_r   <= '0;
            if ((op_r == arctu_pkg::OP_EULER_ROT) || (op_r == arctu_pkg::OP_SET_EULER)) begin
              state_r <= ST_COEF;
            end else begin
              state_r <= ST_APPLY;
            end
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        ST_COEF: begin
          if (cnt_r == 4'(arctu_pkg::COEF_STEPS - 1)) begin
            cnt_r   <= '0;
            state_r <= ST_CDRAIN;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        ST_CDRAIN: begin
          if (cnt_r == 4'd1) begin
            cnt_r   <= '0;
            state_r <= is_compose ? ST_APPLY : ST_COMMIT;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        ST_APPLY: begin
          if ((is_compose && (t_r == 2'd2)) || (!is_compose && (t_r == 2'd3))) begin
            t_r <= '0;
            if ((is_compose && (e_r == 4'd11)) || (!is_compose && (e_r == 4'd3))) begin
              cnt_r   <= '0;
              state_r <= ST_ADRAIN;
            end else begin
              e_r <= e_r + 4'd1;
            end
          end else begin
            t_r <= t_r + 2'd1;
          end
        end
        ST_ADRAIN: begin
          if (cnt_r == 4'd1) begin
            state_r <= ST_COMMIT;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        ST_COMMIT: begin
          if (op_r == arctu_pkg::OP_SET_EULER) begin
            for (int c = 0; c < 3; c++) begin
              for (int k = 0; k < 3; k++) begin
                m_r[c*3 + k] <= frac_of(coef_r[k*3 + c]);
              end
            end
            m_r[9]  <= '0;
            m_r[10] <= '0;
            m_r[11] <= '0;
          end else begin
            // axis rotations keep the untouched row of every column
            for (int c = 0; c < 4; c++) begin
              for (int k = 0; k < 3; k++) begin
                if (is_compose || (2'(k) != fixk)) begin
                  m_r[c*3 + k] <= new_r[c*3 + k];
                end
              end
            end
          end
          oidx_r  <= '0;
          state_r <= ST_OUT;
        end
        default: begin
          if (out_tready) begin
            if (oidx_r == 4'd11) begin
              state_r <= ST_IDLE;
            end else begin
              oidx_r <= oidx_r + 4'd1;
            end
          end
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/arctu_sine.sv
// Quarter-wave sine ROM with quadrant folding; the ROM read is registered.
module arctu_sine #(
  parameter int QUARTER_SINE_DEPTH = arctu_pkg::QUARTER_SINE_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic [arctu_pkg::ANGLE_W-1:0]          angle,
  output logic signed [arctu_pkg::TRIG_W-1:0]    value
);

  localparam int IDX_W = $clog2(QUARTER_SINE_DEPTH + 1);
  localparam int PH_W  = 15;
  localparam int SC_W  = PH_W + IDX_W;

  typedef logic [15:0] rom_t [QUARTER_SINE_DEPTH+1];

  // Entry i: Q1.15 sine of i/DEPTH quarter turns, fixed Q30 Taylor series
  function automatic logic [15:0] rom_entry(input longint unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          s;
    x    = (i * 64'd1686629713) / QUARTER_SINE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    s    = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = (term * x2) >> 30;
      unique case (k)
        1:       term = term / 6;
        2:       term = term / 20;
        3:       term = term / 42;
        4:       term = term / 72;
        5:       term = term / 110;
        6:       term = term / 156;
        7:       term = term / 210;
        default: term = term / 272;
      endcase
      if ((k % 2) == 1) begin
        s = s - longint'(term);
      end else begin
        s = s + longint'(term);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    s = ((s * 32768) + (64'sd1 <<< 29)) >>> 30;
    if (s > 32768) begin
      s = 32768;
    end
    return s[15:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i <= QUARTER_SINE_DEPTH; i++) begin
      r[i] = rom_entry(longint'(i));
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [1:0]       quad;
  logic [PH_W-1:0]  ph;
  logic [SC_W-1:0]  scaled;
  logic [IDX_W-1:0] idx;
  logic [15:0]      rom_q;
  logic             neg_q;

  // Fold the angle onto the first quadrant
  assign quad   = angle[15:14];
  assign ph     = quad[0] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
  assign scaled = SC_W'(ph) * SC_W'(QUARTER_SINE_DEPTH);
  assign idx    = scaled[14 +: IDX_W];

  always_ff @(posedge clk) begin
    rom_q <= ROM[idx];
    neg_q <= quad[1];
  end

  assign value = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

endmodule

FILE: hw/rtl/arctu_mac.sv
// Shared multiply-accumulate unit: multiply, accumulate, round and saturate.
module arctu_mac (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  issue,
  input  logic signed [arctu_pkg::VALUE_W-1:0]  a,
  input  logic signed [arctu_pkg::COEF_W-1:0]   b,
  input  arctu_pkg::mac_ctl_t                   ctl,
  output arctu_pkg::mac_ctl_t                   res_ctl,
  output logic signed [arctu_pkg::VALUE_W-1:0]  res_value
);

  localparam int AW = arctu_pkg::ACC_W;

  logic signed [arctu_pkg::PROD_W-1:0] prod_r;
  arctu_pkg::mac_ctl_t                 ctl1_r;
  arctu_pkg::mac_ctl_t                 ctl2_r;
  logic signed [AW-1:0]                acc_r;
  logic signed [AW-1:0]                term_ext;
  logic signed [AW-1:0]                term;
  logic signed [AW-1:0]                acc_nxt;
  logic signed [AW-1:0]                rnd;

  // Stage 1: product
  always_ff @(posedge clk) begin
    prod_r <= arctu_pkg::PROD_W'(a) * arctu_pkg::PROD_W'(b);
  end

  // Stage 2: accumulate
  assign term_ext = AW'(prod_r);
  always_comb begin
    term = ctl1_r.sh ? (term_ext <<< 15) : term_ext;
    if (ctl1_r.neg) begin
      term = -term;
    end
    acc_nxt = (ctl1_r.clr ? '0 : acc_r) + term;
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= issue ? ctl : '0;
      ctl2_r <= ctl1_r;
    end
  end

  // Stage 3: round to nearest per destination (pair results unrounded), then saturate
  always_comb begin
    unique case (ctl2_r.dsel)
      arctu_pkg::DST_PAIR: rnd = acc_r;
      arctu_pkg::DST_COEF: rnd = (acc_r + AW'(64'sd536870912)) >>> 30;
      default:             rnd = (acc_r + AW'(64'sd16384)) >>> 15;
    endcase
    if (rnd > AW'(64'sd2147483647)) begin
      res_value = 32'sh7fffffff;
    end else if (rnd < AW'(-64'sd2147483648)) begin
      res_value = 32'sh80000000;
    end else begin
      res_value = rnd[31:0];
    end
  end

  assign res_ctl = ctl2_r;

endmodule

FILE: tb/tb_affine_rotation_transform_unit_core.sv
// Self-checking testbench for the affine rotation transform unit core.
`timescale 1ns / 100ps

module tb_affine_rotation_transform_unit_core;

  localparam int FRAC = arctu_pkg::FRACTION_BITS_DEF;
  localparam int QDEPTH = arctu_pkg::QUARTER_SINE_DEPTH_DEF;
  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam longint ONE_Q15 = 64'd32768;

  typedef struct {
    logic [arctu_pkg::OPCODE_W-1:0] opcode;
    logic [arctu_pkg::ANGLE_W-1:0]  ax, ay, az;
    logic [arctu_pkg::VALUE_W-1:0]  vx, vy, vz;
  } xform_cmd_t;

  typedef struct {
    logic [arctu_pkg::INDEX_W-1:0] idx;
    logic [31:0]                   value;
    logic                          last;
  } element_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [3:0]   in_tuser = '0;
  logic [143:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [3:0]   out_tuser;
  logic [31:0]  out_tdata;
  logic         out_tlast;

  affine_rotation_transform_unit_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tuser(out_tuser), .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state and expected element stream
  longint   mat[12];
  longint   sine_rom[QDEPTH+1];
  element_t pending_elems[$];
  int       mismatches = 0;
  int       errors = 0;
  bit       hold_off = 1'b0;
  bit       stim_done = 1'b0;

  function automatic longint round_sh(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint taylor_sine(longint i);
    longint unsigned x, x2, term;
    longint s;
    x = (longint'(i) * HALF_PI_Q30) / QDEPTH;
    x2 = (x * x) >> 30;
    term = x;
    s = x;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k & 1) s -= term;
      else s += term;
    end
    if (s < 0) s = 0;
    s = (s * ONE_Q15 + (64'sd1 <<< 29)) >>> 30;
    if (s > ONE_Q15) s = ONE_Q15;
    return s;
  endfunction

  function automatic longint sin_turn(logic [15:0] a);
    logic [1:0] quad;
    longint p, ph, m;
    quad = a[15:14];
    p = a[13:0];
    ph = quad[0] ? 16384 - p : p;
    m = sine_rom[(ph * QDEPTH) >> 14];
    return quad[1] ? -m : m;
  endfunction

  function automatic longint cos_turn(logic [15:0] a);
    return sin_turn(a + 16'd16384);
  endfunction

  function automatic longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  task automatic set_orient(longint d);
    for (int k = 0; k < 9; k++) mat[k] = 0;
    mat[0] = d; mat[4] = d; mat[8] = d;
  endtask

  task automatic load_identity();
    set_orient(64'sd1 <<< FRAC);
    mat[9] = 0; mat[10] = 0; mat[11] = 0;
  endtask

  task automatic rotate_pair(int i, int j, logic [15:0] ang);
    longint s, c, a, b;
    s = sin_turn(ang);
    c = cos_turn(ang);
    for (int col = 0; col < 12; col += 3) begin
      a = mat[col + i];
      b = mat[col + j];
      mat[col + i] = sat(round_sh(c * a - s * b, 15));
      mat[col + j] = sat(round_sh(c * b + s * a, 15));
    end
  endtask

  task automatic euler_matrix(xform_cmd_t c, output longint r[3][3]);
    longint sX, cX, sY, cY, sZ, cZ;
    sX = sin_turn(c.ax); cX = cos_turn(c.ax);
    sY = sin_turn(c.ay); cY = cos_turn(c.ay);
    sZ = sin_turn(c.az); cZ = cos_turn(c.az);
    r[0][0] = round_sh(cZ * cY * ONE_Q15 - sZ * sX * sY, 30);
    r[1][0] = round_sh(cZ * sX * sY + sZ * cY * ONE_Q15, 30);
    r[2][0] = round_sh(-cX * sY * ONE_Q15, 30);
    r[0][1] = round_sh(-sZ * cX * ONE_Q15, 30);
    r[1][1] = round_sh(cZ * cX * ONE_Q15, 30);
    r[2][1] = round_sh(sX * ONE_Q15 * ONE_Q15, 30);
    r[0][2] = round_sh(sZ * sX * cY + cZ * sY * ONE_Q15, 30);
    r[1][2] = round_sh(sZ * sY * ONE_Q15 - cZ * sX * cY, 30);
    r[2][2] = round_sh(cX * cY * ONE_Q15, 30);
  endtask

  // Apply one command to the model matrix and queue the twelve elements
  task automatic predict_elements(xform_cmd_t c);
    longint r[3][3];
    longint a0, a1, a2;
    element_t e;
    case (c.opcode)
      arctu_pkg::OP_IDENTITY: load_identity();
      arctu_pkg::OP_SCALE: begin
        set_orient(sx32(c.vx));
        mat[9] = 0; mat[10] = 0; mat[11] = 0;
      end
      arctu_pkg::OP_TRANSLATE: begin
        set_orient(64'sd1 <<< FRAC);
        mat[9] = sx32(c.vx); mat[10] = sx32(c.vy); mat[11] = sx32(c.vz);
      end
      arctu_pkg::OP_ROTX: rotate_pair(1, 2, c.ax);
      arctu_pkg::OP_ROTY: rotate_pair(2, 0, c.ay);
      arctu_pkg::OP_ROTZ: rotate_pair(0, 1, c.az);
      arctu_pkg::OP_EULER_ROT: begin
        euler_matrix(c, r);
        for (int col = 0; col < 12; col += 3) begin
          a0 = mat[col]; a1 = mat[col + 1]; a2 = mat[col + 2];
          for (int k = 0; k < 3; k++)
            mat[col + k] = sat(round_sh(r[k][0] * a0 + r[k][1] * a1 + r[k][2] * a2, 15));
        end
      end
      arctu_pkg::OP_SET_EULER: begin
        euler_matrix(c, r);
        for (int col = 0; col < 3; col++)
          for (int k = 0; k < 3; k++)
            mat[col * 3 + k] = (FRAC >= 15) ? sat(r[k][col] <<< (FRAC - 15))
                                            : sat(round_sh(r[k][col], 15 - FRAC));
        mat[9] = 0; mat[10] = 0; mat[11] = 0;
      end
      arctu_pkg::OP_RESET_ORIENT: set_orient(64'sd1 <<< FRAC);
      default: ;
    endcase
    for (int k = 0; k < 12; k++) begin
      e.idx = 4'(k);
      e.value = mat[k][31:0];
      e.last = (k == 11);
      pending_elems.push_back(e);
    end
  endtask

  // Directed table; a row with a typed value also checks that element index
  typedef struct {
    xform_cmd_t cmd;
    int         chk_idx;
    logic [31:0] chk_val;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic xform_cmd_t mk_cmd(logic [3:0] op, logic [15:0] ax, logic [15:0] ay,
                                        logic [15:0] az, logic [31:0] vx, logic [31:0] vy,
                                        logic [31:0] vz);
    xform_cmd_t c;
    c.opcode = op; c.ax = ax; c.ay = ay; c.az = az;
    c.vx = vx; c.vy = vy; c.vz = vz;
    return c;
  endfunction

  function automatic xform_cmd_t rand_cmd();
    xform_cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) c.opcode = arctu_pkg::OP_IDENTITY;
    else if (pick < 12) c.opcode = arctu_pkg::OP_SCALE;
    else if (pick < 20) c.opcode = arctu_pkg::OP_TRANSLATE;
    else if (pick < 35) c.opcode = arctu_pkg::OP_ROTX;
    else if (pick < 50) c.opcode = arctu_pkg::OP_ROTY;
    else if (pick < 65) c.opcode = arctu_pkg::OP_ROTZ;
    else if (pick < 82) c.opcode = arctu_pkg::OP_EULER_ROT;
    else if (pick < 90) c.opcode = arctu_pkg::OP_SET_EULER;
    else if (pick < 95) c.opcode = arctu_pkg::OP_RESET_ORIENT;
    else c.opcode = 4'($urandom_range(9, 15));
    c.ax = 16'($urandom); c.ay = 16'($urandom); c.az = 16'($urandom);
    // mostly modest values so rotations stay out of saturation, some full range
    if ($urandom_range(0, 3) == 0) begin
      c.vx = $urandom; c.vy = $urandom; c.vz = $urandom;
    end else begin
      c.vx = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      c.vy = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      c.vz = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    end
    return c;
  endfunction

  // Typed checks carried alongside the element queue
  int       typed_idx[$];
  logic [31:0] typed_val[$];

  task automatic send_cmd(xform_cmd_t c, int cidx, logic [31:0] cval);
    in_tvalid <= 1'b1;
    in_tuser <= c.opcode;
    in_tdata <= {c.vz, c.vy, c.vx, c.az, c.ay, c.ax};
    do @(posedge clk); while (!in_tready);
    predict_elements(c);
    typed_idx.push_back(cidx);
    typed_val.push_back(cval);
  endtask

  task automatic drain_wait();
    in_tvalid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
  endtask

  // Sender
  initial begin
    int burst;
    for (int i = 0; i <= QDEPTH; i++) sine_rom[i] = taylor_sine(longint'(i));
    load_identity();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_rows.push_back('{mk_cmd(4'd15, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0),
                         0, 32'h0001_0000});
    dir_rows.push_back('{mk_cmd(arctu_pkg::OP_TRANSLATE, 16'h0, 16'h0, 16'h0,
                                32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF),
                         9, 32'h7FFF_FFFF});
    dir_rows.push_back('{mk_cmd(arctu_pkg::OP_ROTX, 16'h4000, 16'h0, 16'h0,
                                32'h0, 32'h0, 32'h0), -1, 32'h0});
    dir_rows.push_back('{mk_cmd(arctu_pkg::OP_ROTY, 16'h0, 16'hFFFF, 16'h0,
                                32'h0, 32'h0, 32'h0), -1, 32'h0});
    dir_rows.push_back('{mk_cmd(arctu_pkg::OP_ROTZ, 16'h0, 16'h0, 16'h8000,
                                32'h0, 32'h0, 32'h0), -1, 32'h0});
    dir_rows.push_back('{mk_cmd(arctu_pkg::OP_RESET_ORIENT, 16'h0, 16'h0, 16'h0,
                                32'h0, 32'h0, 32'h0), 4, 32'h0001_0000});
    dir_rows.push_back('{mk_cmd(arctu_pkg::OP_SCALE, 16'h0, 16'h0, 16'h0,
                                32'h8000_0000, 32'h0, 32'h0), 0, 32'h8000_0000});
    dir_rows.push_back('{mk_cmd(arctu_pkg::OP_ROTZ, 16'h0, 16'h0, 16'h2000,
                                32'h0, 32'h0, 32'h0), -1, 32'h0});
    dir_rows.push_back('{mk_cmd(arctu_pkg::OP_SCALE, 16'h0, 16'h0, 16'h0,
                                32'h7FFF_FFFF, 32'h0, 32'h0), 8, 32'h7FFF_FFFF});
    dir_rows.push_back('{mk_cmd(arctu_pkg::OP_EULER_ROT, 16'h1000, 16'h2000, 16'h3000,
                                32'h0, 32'h0, 32'h0), -1, 32'h0});
    dir_rows.push_back('{mk_cmd(arctu_pkg::OP_IDENTITY, 16'h0, 16'h0, 16'h0,
                                32'h0, 32'h0, 32'h0), 11, 32'h0});
    dir_rows.push_back('{mk_cmd(arctu_pkg::OP_SET_EULER, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                32'h0, 32'h0, 32'h0), -1, 32'h0});
    dir_rows.push_back('{mk_cmd(arctu_pkg::OP_SET_EULER, 16'h4000, 16'hC000, 16'h8000,
                                32'h0, 32'h0, 32'h0), -1, 32'h0});
    dir_rows.push_back('{mk_cmd(arctu_pkg::OP_TRANSLATE, 16'h0, 16'h0, 16'h0,
                                32'h0003_0000, 32'hFFFE_0000, 32'h0000_8000), -1, 32'h0});
    dir_rows.push_back('{mk_cmd(arctu_pkg::OP_EULER_ROT, 16'hFFFF, 16'h0001, 16'h7FFF,
                                32'h0, 32'h0, 32'h0), -1, 32'h0});
    dir_rows.push_back('{mk_cmd(arctu_pkg::OP_ROTX, 16'hC000, 16'h0, 16'h0,
                                32'h0, 32'h0, 32'h0), -1, 32'h0});
    dir_rows.push_back('{mk_cmd(4'd9, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0),
                         -1, 32'h0});
    dir_rows.push_back('{mk_cmd(arctu_pkg::OP_SET_EULER, 16'h0, 16'h0, 16'h0,
                                32'h0, 32'h0, 32'h0), 9, 32'h0});

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].cmd, dir_rows[i].chk_idx, dir_rows[i].chk_val);

    // one pause until the block is fully drained
    drain_wait();

    // random bursts with gaps; a long output hold-off early on
    hold_off = 1'b1;
    for (int n = 0; n < 250; ) begin
      burst = $urandom_range(1, 8);
      for (int b = 0; b < burst && n < 250; b++, n++)
        send_cmd(rand_cmd(), -1, 32'h0);
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    stim_done <= 1'b1;
  end

  // Receiver: random stall pattern, one long hold-off
  initial begin
    int mode;
    wait (rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      mode = $urandom_range(0, 2);
      for (int k = 0; k < 50; k++) begin
        if (hold_off) break;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Output checker
  int elem_in_run = 0;
  always @(posedge clk) begin
    element_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_elems.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected element idx=%0d val=%h", out_tuser, out_tdata);
      end else begin
        e = pending_elems.pop_front();
        if (out_tuser !== e.idx || out_tdata !== e.value || out_tlast !== e.last) begin
          errors++;
          if (mismatches++ < 10)
            $display("element mismatch: exp idx=%0d val=%h last=%b got idx=%0d val=%h last=%b",
                     e.idx, e.value, e.last, out_tuser, out_tdata, out_tlast);
        end
        if (typed_idx.size() != 0 && typed_idx[0] == elem_in_run &&
            out_tdata !== typed_val[0]) begin
          errors++;
          if (mismatches++ < 10)
            $display("directed value mismatch idx=%0d exp=%h got=%h",
                     elem_in_run, typed_val[0], out_tdata);
        end
        if (elem_in_run == 11) begin
          elem_in_run = 0;
          if (typed_idx.size() != 0) begin
            void'(typed_idx.pop_front());
            void'(typed_val.pop_front());
          end
        end else begin
          elem_in_run++;
        end
      end
    end
  end

  // End of run
  initial begin
    wait (stim_done);
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_elems.size() == 0) begin
      $display("tb_affine_rotation_transform_unit_core OK");
    end else begin
      $display("tb_affine_rotation_transform_unit_core NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("tb_affine_rotation_transform_unit_core NOT OK");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/arctu_pkg.sv
hw/rtl/arctu_sine.sv
hw/rtl/arctu_mac.sv
hw/rtl/affine_rotation_transform_unit_core.sv
tb/tb_affine_rotation_transform_unit_core.sv
